// ===== src/ffba_pkg.sv =====
// Shared types, constants and helpers for the first-fit block allocator.
// No dependencies; every other file imports this package.
package ffba_pkg;

  localparam int NODES   = 128;
  localparam int IDX_W   = $clog2(NODES);
  localparam int AW      = 15;
  localparam logic [AW-1:0] POOL_RESET = AW'(8640);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [AW-1:0]    addr_t;

  // command codes
  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_REINIT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SRCH_FIT,
    OP_SRCH_HIT,
    OP_READ_I,
    OP_READ_REL,
    OP_SPLIT,
    OP_TAKE,
    OP_SRCH_NEXT,
    OP_MERGE_NEXT,
    OP_SRCH_PREV,
    OP_MERGE_PREV,
    OP_INIT,
    OP_RESULT
  } op_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_A_SRCH,
    S_A_READ,
    S_A_WRITE,
    S_F_SRCH,
    S_F_READ,
    S_F_NEXT,
    S_F_MNEXT,
    S_F_PREV,
    S_F_MPREV,
    S_INIT,
    S_RESP,
    S_OUT
  } state_t;

  typedef struct packed {
    op_t     op;
    status_t res_status;
    logic    res_off_en;
    logic    in_ready;
    logic    out_valid;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic size_zero;
    logic i_found;
    logic j_found;
    logic longer;
  } dp_stat_t;

  typedef struct packed {
    logic found;
    idx_t idx;
  } pick_t;

  // lowest set bit of a hit vector
  function automatic pick_t first_one(input logic [NODES-1:0] v);
    pick_t p;
    p.found = 1'b0;
    p.idx   = '0;
    for (int k = NODES - 1; k >= 0; k--) begin
      if (v[k]) begin
        p.found = 1'b1;
        p.idx   = IDX_W'(k);
      end
    end
    return p;
  endfunction

endpackage

// ===== src/ffba_if.sv =====
// Handshake channel interfaces: request, result and configuration words.
// Depends on ffba_pkg.
interface ffba_in_if;
  import ffba_pkg::*;
  logic  valid;
  logic  ready;
  logic [1:0] command;
  addr_t request_size;
  addr_t free_offset;
  modport source (output valid, command, request_size, free_offset, input ready);
  modport sink   (input valid, command, request_size, free_offset, output ready);
endinterface

interface ffba_out_if;
  import ffba_pkg::*;
  logic  valid;
  logic  ready;
  logic [1:0] status;
  addr_t offset;
  modport source (output valid, status, offset, input ready);
  modport sink   (input valid, status, offset, output ready);
endinterface

interface ffba_cfg_if;
  import ffba_pkg::*;
  logic  valid;
  logic  ready;
  addr_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator: controller plus datapath.
// Depends on ffba_pkg, ffba_if, ffba_ctrl and ffba_dp.
//
//  channel  dir  word
//  in_ch    in   command, request_size, free_offset
//  out_ch   out  status, offset
//  cfg_ch   in   pool size (always ready)
//
// One request at a time. Allocate runs search, read and write steps; free runs search,
// read, next-merge and previous-merge steps; reinitialise runs init; then the result.
// Reset (synchronous) loads one free span of 8640 bytes.
// A stalled result holds the block until taken.
module first_fit_block_allocator (
  input  logic       clk,
  input  logic       rst_n,
  ffba_in_if.sink    in_ch,
  ffba_out_if.source out_ch,
  ffba_cfg_if.sink   cfg_ch
);
  import ffba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_fire, out_fire;

  assign in_fire      = in_ch.valid && cmd.in_ready;
  assign out_fire     = out_ch.ready && cmd.out_valid;
  assign in_ch.ready  = cmd.in_ready;
  assign out_ch.valid = cmd.out_valid;
  assign cfg_ch.ready = 1'b1;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_fire (out_fire),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffba_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_command (in_ch.command),
    .in_size    (in_ch.request_size),
    .in_where   (in_ch.free_offset),
    .cfg_we     (cfg_ch.valid),
    .cfg_data   (cfg_ch.data),
    .stat       (stat),
    .res_status (out_ch.status),
    .res_offset (out_ch.offset)
  );

endmodule

// ===== src/ffba_ctrl.sv =====
// Controller state machine: sequences searches, reads and table updates.
// Depends on ffba_pkg.
module ffba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_fire,
  input  ffba_pkg::dp_stat_t stat,
  output ffba_pkg::dp_cmd_t  cmd
);
  import ffba_pkg::*;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_DECODE;
      S_DECODE: begin
        st_nxt = ST_OK;
        unique case (stat.cmd)
          CMD_ALLOC: begin
            if (stat.size_zero) begin
              st_nxt    = ST_NOFIT;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_A_SRCH;
            end
          end
          CMD_FREE:   state_nxt = S_F_SRCH;
          CMD_REINIT: state_nxt = S_INIT;
          default:    state_nxt = S_RESP;
        endcase
      end
      S_A_SRCH: state_nxt = S_A_READ;
      S_A_READ: begin
        if (stat.i_found) begin
          state_nxt = S_A_WRITE;
        end else begin
          st_nxt    = ST_NOFIT;
          state_nxt = S_RESP;
        end
      end
      S_A_WRITE: begin
        if (stat.longer && !stat.j_found) st_nxt = ST_FULL;
        state_nxt = S_RESP;
      end
      S_F_SRCH: state_nxt = S_F_READ;
      S_F_READ: begin
        if (stat.i_found) begin
          state_nxt = S_F_NEXT;
        end else begin
          st_nxt    = ST_BADFREE;
          state_nxt = S_RESP;
        end
      end
      S_F_NEXT:  state_nxt = S_F_MNEXT;
      S_F_MNEXT: state_nxt = S_F_PREV;
      S_F_PREV:  state_nxt = S_F_MPREV;
      S_F_MPREV: state_nxt = S_RESP;
      S_INIT:    state_nxt = S_RESP;
      S_RESP:    state_nxt = S_OUT;
      S_OUT:     if (out_fire) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd            = '0;
    cmd.op         = OP_NOP;
    cmd.res_status = st_r;
    cmd.res_off_en = (stat.cmd == CMD_ALLOC) && (st_r == ST_OK);
    unique case (state_r)
      // request word is captured every idle cycle; the one at the accept edge stays
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.op       = OP_LOAD;
      end
      S_A_SRCH: cmd.op = OP_SRCH_FIT;
      S_A_READ: if (stat.i_found) cmd.op = OP_READ_I;
      S_A_WRITE: begin
        if (!stat.longer)      cmd.op = OP_TAKE;
        else if (stat.j_found) cmd.op = OP_SPLIT;
      end
      S_F_SRCH:  cmd.op = OP_SRCH_HIT;
      S_F_READ:  if (stat.i_found) cmd.op = OP_READ_REL;
      S_F_NEXT:  cmd.op = OP_SRCH_NEXT;
      S_F_MNEXT: if (stat.j_found) cmd.op = OP_MERGE_NEXT;
      S_F_PREV:  cmd.op = OP_SRCH_PREV;
      S_F_MPREV: if (stat.j_found) cmd.op = OP_MERGE_PREV;
      S_INIT:    cmd.op = OP_INIT;
      S_RESP:    cmd.op = OP_RESULT;
      S_OUT:     cmd.out_valid = 1'b1;
      default:   cmd.op = OP_NOP;
    endcase
  end

endmodule

// ===== src/ffba_dp.sv =====
// Datapath: descriptor table, parallel match lanes, priority pick and result word.
// Depends on ffba_pkg.
module ffba_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  ffba_pkg::dp_cmd_t  cmd,
  input  logic [1:0]         in_command,
  input  ffba_pkg::addr_t    in_size,
  input  ffba_pkg::addr_t    in_where,
  input  logic               cfg_we,
  input  ffba_pkg::addr_t    cfg_data,
  output ffba_pkg::dp_stat_t stat,
  output logic [1:0]         res_status,
  output ffba_pkg::addr_t    res_offset
);
  import ffba_pkg::*;

  logic  valid_r [NODES];
  logic  busy_r  [NODES];
  addr_t start_r [NODES];
  addr_t len_r   [NODES];

  addr_t pool_r;
  cmd_t  cmd_r;
  addr_t size_r, where_r, sel_start_r, sel_len_r;
  logic [AW:0] end_r;
  idx_t  idx_i_r, idx_j_r;
  logic  i_found_r, j_found_r;
  logic [1:0] res_status_r;
  addr_t res_offset_r;

  logic [NODES-1:0] fit_v, hole_v, hit_v, next_v, prev_v;
  pick_t fit_p, hole_p, hit_p, next_p, prev_p;
  addr_t merged_len;

  // per-entry match lanes
  always_comb begin
    for (int k = 0; k < NODES; k++) begin
      fit_v[k]  = valid_r[k] && !busy_r[k] && (len_r[k] >= size_r);
      hole_v[k] = !valid_r[k];
      hit_v[k]  = valid_r[k] && busy_r[k] && (start_r[k] == where_r);
      next_v[k] = (idx_t'(k) != idx_i_r) && valid_r[k] && !busy_r[k] &&
                  ({1'b0, start_r[k]} == end_r);
      prev_v[k] = (idx_t'(k) != idx_i_r) && valid_r[k] && !busy_r[k] &&
                  (({1'b0, start_r[k]} + {1'b0, len_r[k]}) == {1'b0, sel_start_r});
    end
  end

  assign fit_p  = first_one(fit_v);
  assign hole_p = first_one(hole_v);
  assign hit_p  = first_one(hit_v);
  assign next_p = first_one(next_v);
  assign prev_p = first_one(prev_v);

  assign merged_len = (cmd.op == OP_MERGE_NEXT) ? AW'(sel_len_r + len_r[idx_j_r])
                                                : AW'(len_r[idx_j_r] + sel_len_r);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) pool_r <= POOL_RESET;
    else if (cfg_we) pool_r <= cfg_data;
  end

  // descriptor table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NODES; k++) begin
        valid_r[k] <= (k == 0);
        busy_r[k]  <= 1'b0;
        start_r[k] <= '0;
        len_r[k]   <= (k == 0) ? POOL_RESET : '0;
      end
    end else begin
      case (cmd.op)
        OP_INIT: begin
          for (int k = 0; k < NODES; k++) begin
            valid_r[k] <= (k == 0);
            busy_r[k]  <= 1'b0;
            start_r[k] <= '0;
            len_r[k]   <= (k == 0) ? pool_r : '0;
          end
        end
        OP_SPLIT: begin
          valid_r[idx_j_r] <= 1'b1;
          busy_r[idx_j_r]  <= 1'b0;
          start_r[idx_j_r] <= AW'(sel_start_r + size_r);
          len_r[idx_j_r]   <= AW'(sel_len_r - size_r);
          busy_r[idx_i_r]  <= 1'b1;
          len_r[idx_i_r]   <= size_r;
        end
        OP_TAKE: begin
          busy_r[idx_i_r] <= 1'b1;
          len_r[idx_i_r]  <= size_r;
        end
        OP_READ_REL: busy_r[idx_i_r] <= 1'b0;
        OP_MERGE_NEXT: begin
          len_r[idx_i_r]   <= merged_len;
          valid_r[idx_j_r] <= 1'b0;
          busy_r[idx_j_r]  <= 1'b0;
          start_r[idx_j_r] <= '0;
          len_r[idx_j_r]   <= '0;
        end
        OP_MERGE_PREV: begin
          len_r[idx_j_r]   <= merged_len;
          valid_r[idx_i_r] <= 1'b0;
          busy_r[idx_i_r]  <= 1'b0;
          start_r[idx_i_r] <= '0;
          len_r[idx_i_r]   <= '0;
        end
        default: ;
      endcase
    end
  end

  // request word, search results and selected entry
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_r   <= cmd_t'(in_command);
        size_r  <= in_size;
        where_r <= in_where;
      end
      OP_SRCH_FIT: begin
        idx_i_r   <= fit_p.idx;
        i_found_r <= fit_p.found;
        idx_j_r   <= hole_p.idx;
        j_found_r <= hole_p.found;
      end
      OP_SRCH_HIT: begin
        idx_i_r   <= hit_p.idx;
        i_found_r <= hit_p.found;
      end
      OP_READ_I, OP_READ_REL: begin
        sel_start_r <= start_r[idx_i_r];
        sel_len_r   <= len_r[idx_i_r];
        end_r       <= {1'b0, start_r[idx_i_r]} + {1'b0, len_r[idx_i_r]};
      end
      OP_SRCH_NEXT: begin
        idx_j_r   <= next_p.idx;
        j_found_r <= next_p.found;
      end
      OP_MERGE_NEXT: sel_len_r <= merged_len;
      OP_SRCH_PREV: begin
        idx_j_r   <= prev_p.idx;
        j_found_r <= prev_p.found;
      end
      OP_RESULT: begin
        res_status_r <= cmd.res_status;
        res_offset_r <= cmd.res_off_en ? sel_start_r : '0;
      end
      default: ;
    endcase
  end

  assign stat.cmd       = cmd_r;
  assign stat.size_zero = (size_r == '0);
  assign stat.i_found   = i_found_r;
  assign stat.j_found   = j_found_r;
  assign stat.longer    = (sel_len_r > size_r);
  assign res_status     = res_status_r;
  assign res_offset     = res_offset_r;

endmodule
